[design/deq_pkg.sv]
// types, codes and sizes shared by the deque cells, top level and checker
package deq_pkg;

   localparam int DEQ_DEPTH = 64;
   localparam int DATA_W    = 32;
   localparam int OCC_W     = 7;
   localparam int CMD_W     = 2;
   localparam int STATUS_W  = 2;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 40;

   // response tdata bit positions
   localparam int RSP_OCC_LSB   = DATA_W;
   localparam int RSP_EMPTY_BIT = DATA_W + OCC_W;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_FRONT = 2'd0,
      CMD_PUSH_BACK  = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_POP_BACK   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2
   } status_type;

   // operation broadcast to every cell of the row
   typedef struct packed {
      logic push_front;
      logic push_back;
      logic pop_front;
      logic pop_back;
   } cell_ctrl_type;

endpackage

[design/deq_cell.sv]
// one storage cell of the deque row, shifting toward either neighbor
module deq_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  deq_pkg::cell_ctrl_type       ctrl,
   input  logic [deq_pkg::DATA_W-1:0]   push_word,
   input  logic [deq_pkg::DATA_W-1:0]   left_data,
   input  logic                         left_valid,
   input  logic [deq_pkg::DATA_W-1:0]   right_data,
   input  logic                         right_valid,
   output logic [deq_pkg::DATA_W-1:0]   data,
   output logic                         valid,
   output logic [deq_pkg::DATA_W-1:0]   tail_data
);
   import deq_pkg::*;

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;
   logic              valid_ff;
   logic              valid_in;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (ctrl.push_front) begin
         data_in  = left_data;
         valid_in = left_valid;
      end else if (ctrl.pop_front) begin
         data_in  = right_data;
         valid_in = right_valid;
      end else if (ctrl.push_back) begin
         if (!valid_ff && left_valid) begin
            data_in  = push_word;
            valid_in = 1'b1;
         end
      end else if (ctrl.pop_back) begin
         if (valid_ff && !right_valid) begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign data      = data_ff;
   assign valid     = valid_ff;
   // only the last occupied cell drives its word onto the tail bus
   assign tail_data = (valid_ff && !right_valid) ? data_ff : '0;

endmodule

[design/double_ended_queue.sv]
// deque top level: command decode, row of shifting cells and registered response
// the response is registered: it becomes valid in the cycle after the request is accepted
// throughput: one request per cycle while responses are taken; a stalled response holds off requests
// front is cell 0; front pushes and pops shift the whole row by one cell at once
// reset: synchronous, clears cell valid bits, occupancy and response valid; words are not cleared
// a pop on empty returns zero with underflow status, a push on full is dropped with overflow
module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEQ_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [deq_pkg::REQ_DATA_W-1:0]   req_tdata,  // push_value[31:0]
   input  logic [deq_pkg::CMD_W-1:0]        req_tuser,  // command[1:0]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // popped_value[31:0], occupancy[38:32], is_empty[39]
   output logic [deq_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [deq_pkg::STATUS_W-1:0]     rsp_tuser   // status[1:0]
);
   import deq_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] cell_data  [DEPTH];
   logic              cell_valid [DEPTH];
   logic [DATA_W-1:0] cell_tail  [DEPTH];

   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   status_type            rsp_status_ff;
   status_type            rsp_status_in;

   logic              accept;
   logic              full;
   logic              empty;
   cmd_type           cmd;
   cell_ctrl_type     ctrl;
   logic [DATA_W-1:0] tail_word;
   logic [DATA_W-1:0] popped;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign cmd        = cmd_type'(req_tuser);
   assign full       = (count_ff == CNT_W'(DEPTH));
   assign empty      = (count_ff == '0);

   always_comb begin
      ctrl          = '0;
      rsp_status_in = ST_OK;
      count_in      = count_ff;
      unique case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (full) begin
               rsp_status_in = ST_OVERFLOW;
            end else begin
               ctrl.push_front = accept && (cmd == CMD_PUSH_FRONT);
               ctrl.push_back  = accept && (cmd == CMD_PUSH_BACK);
               count_in        = count_ff + CNT_W'(1);
            end
         end
         CMD_POP_FRONT, CMD_POP_BACK: begin
            if (empty) begin
               rsp_status_in = ST_UNDERFLOW;
            end else begin
               ctrl.pop_front = accept && (cmd == CMD_POP_FRONT);
               ctrl.pop_back  = accept && (cmd == CMD_POP_BACK);
               count_in       = count_ff - CNT_W'(1);
            end
         end
         default: begin
            rsp_status_in = ST_OK;
         end
      endcase
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic              left_valid;
      logic [DATA_W-1:0] right_data;
      logic              right_valid;

      if (i == 0) begin : g_head
         assign left_data  = req_tdata;
         assign left_valid = 1'b1;
      end else begin : g_mid
         assign left_data  = cell_data[i-1];
         assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_data  = '0;
         assign right_valid = 1'b0;
      end else begin : g_next
         assign right_data  = cell_data[i+1];
         assign right_valid = cell_valid[i+1];
      end

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .push_word   (req_tdata),
         .left_data   (left_data),
         .left_valid  (left_valid),
         .right_data  (right_data),
         .right_valid (right_valid),
         .data        (cell_data[i]),
         .valid       (cell_valid[i]),
         .tail_data   (cell_tail[i])
      );
   end

   always_comb begin
      tail_word = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_word = tail_word | cell_tail[i];
      end
   end

   always_comb begin
      popped = '0;
      if (ctrl.pop_front) begin
         popped = cell_data[0];
      end else if (ctrl.pop_back) begin
         popped = tail_word;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {(count_in == '0), OCC_W'(count_in), popped};
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= rsp_status_in;
      end
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

endmodule

[design/deq_checker.sv]
// port-level checks for the deque, bound to the top level
module deq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [deq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [deq_pkg::STATUS_W-1:0]   rsp_tuser
);
   import deq_pkg::*;

   // a stalled response blocks new requests
   a_stall_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request accepted while response stalled");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_EMPTY_BIT] == (rsp_tdata[RSP_EMPTY_BIT-1:RSP_OCC_LSB] == '0))
      else $error("empty flag disagrees with occupancy");

   a_underflow: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_UNDERFLOW
      |-> rsp_tdata[DATA_W-1:0] == '0 && rsp_tdata[RSP_EMPTY_BIT])
      else $error("underflow response not empty or nonzero word");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// self-checking stream testbench for the double_ended_queue block with a ring-buffer predictor
module testbench;
   import deq_pkg::*;

   localparam int DEPTH          = DEQ_DEPTH;
   localparam int WATCHDOG_LIMIT = 400;
   localparam int DRAIN_CYCLES   = 5;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [DATA_W-1:0] popped;
      logic [OCC_W-1:0]  occupancy;
      logic              is_empty;
      status_type        status;
   } deque_result_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // push_value[31:0]
   logic [CMD_W-1:0]      req_tuser;   // command[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // popped_value[31:0], occupancy[38:32], is_empty[39]
   logic [STATUS_W-1:0]   rsp_tuser;   // status[1:0]

   // predictor state
   logic [DATA_W-1:0] ring_words [DEPTH];
   int                head_slot;
   int                stored_count;

   deque_result_type expected_results[$];
   int               error_count;
   int               result_count;
   int               quiet_cycles;
   bit               req_idle_on;
   bit               rsp_idle_on;

   double_ended_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic deque_result_type predict_deque(cmd_type cmd, logic [DATA_W-1:0] word);
      deque_result_type r;
      int               slot;
      r.popped = '0;
      r.status = ST_OK;
      case (cmd)
         CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
            if (stored_count >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else begin
               if (cmd == CMD_PUSH_FRONT) begin
                  head_slot = (head_slot + DEPTH - 1) % DEPTH;
                  slot      = head_slot;
               end else begin
                  slot = (head_slot + stored_count) % DEPTH;
               end
               ring_words[slot] = word;
               stored_count++;
            end
         end
         default: begin
            if (stored_count == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               if (cmd == CMD_POP_FRONT) begin
                  slot      = head_slot;
                  head_slot = (head_slot + 1) % DEPTH;
               end else begin
                  slot = (head_slot + stored_count - 1) % DEPTH;
               end
               r.popped = ring_words[slot];
               stored_count--;
            end
         end
      endcase
      r.occupancy = OCC_W'(stored_count);
      r.is_empty  = (stored_count == 0);
      return r;
   endfunction

   function automatic void report_error(string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("error at %0t: %s", $realtime, what);
   endfunction

   // predict each accepted request, compare each accepted response
   always @(posedge clock) begin : check_results
      deque_result_type want;
      deque_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_results.push_back(predict_deque(cmd_type'(req_tuser), req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.popped    = rsp_tdata[DATA_W-1:0];
            got.occupancy = rsp_tdata[RSP_OCC_LSB +: OCC_W];
            got.is_empty  = rsp_tdata[RSP_EMPTY_BIT];
            got.status    = status_type'(rsp_tuser);
            if (expected_results.size() == 0) begin
               report_error($sformatf("response %0d with no request pending: %h",
                                      result_count, got));
            end else begin
               want = expected_results.pop_front();
               if (got.popped !== want.popped || got.occupancy !== want.occupancy ||
                   got.is_empty !== want.is_empty || got.status !== want.status)
                  report_error($sformatf(
                     "response %0d value %h/%h occ %0d/%0d empty %b/%b status %0d/%0d",
                     result_count, want.popped, got.popped, want.occupancy, got.occupancy,
                     want.is_empty, got.is_empty, want.status, got.status));
            end
            result_count++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // response side: random stall (when rsp_idle_on is set) before taking each response
   initial begin : drive_rsp_ready
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = rsp_idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send_request(input cmd_type cmd, input logic [DATA_W-1:0] word);
      int gap;
      gap = req_idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_underflow();
      send_request(CMD_POP_FRONT, 32'hdead_beef);
      send_request(CMD_POP_BACK, 32'hffff_ffff);
   endtask

   task automatic test_extreme_words();
      send_request(CMD_PUSH_BACK, 32'h7fff_ffff);
      send_request(CMD_PUSH_FRONT, 32'h8000_0000);
      send_request(CMD_PUSH_BACK, 32'h0000_0000);
      send_request(CMD_PUSH_FRONT, 32'hffff_ffff);
      send_request(CMD_PUSH_BACK, 32'h5555_5555);
      send_request(CMD_PUSH_FRONT, 32'haaaa_aaaa);
      repeat (3) send_request(CMD_POP_FRONT, $urandom);
      repeat (3) send_request(CMD_POP_BACK, $urandom);
      send_request(CMD_POP_BACK, 32'h0000_0000);
   endtask

   // fill through the wrap point, push on full, then drain from both ends
   task automatic test_full_and_wrap();
      repeat (DEPTH) send_request(CMD_PUSH_FRONT, pick_word());
      send_request(CMD_PUSH_BACK, pick_word());
      send_request(CMD_PUSH_FRONT, pick_word());
      repeat (8) send_request(CMD_POP_BACK, $urandom);
      repeat (8) send_request(CMD_PUSH_BACK, pick_word());
      send_request(CMD_PUSH_BACK, pick_word());
      for (int n = 0; n < DEPTH; n++)
         send_request((n % 2) ? CMD_POP_BACK : CMD_POP_FRONT, $urandom);
      send_request(CMD_POP_FRONT, $urandom);
   endtask

   // phases with differing push/pop bias so occupancy can sweep empty to full
   task automatic test_random_traffic();
      int push_mix [5] = '{95, 5, 50, 75, 25};
      int push_pct;
      for (int phase = 0; phase < 10; phase++) begin
         push_pct    = push_mix[$urandom_range(0, 4)];
         req_idle_on = ($urandom_range(0, 2) != 0);
         rsp_idle_on = ($urandom_range(0, 2) != 0);
         for (int n = 0; n < 75; n++) begin
            if ($urandom_range(1, 100) <= push_pct)
               send_request(cmd_type'($urandom_range(0, 1)), pick_word());
            else
               send_request(cmd_type'($urandom_range(2, 3)), $urandom);
         end
      end
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = CMD_PUSH_FRONT;
      rsp_tready   = 1'b0;
      head_slot    = 0;
      stored_count = 0;
      error_count  = 0;
      result_count = 0;
      quiet_cycles = 0;
      req_idle_on  = 1'b1;
      rsp_idle_on  = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_underflow();
      test_extreme_words();
      test_full_and_wrap();
      test_random_traffic();

      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
